[rtl/core/rgd_pkg.sv]
// package for the running gcd of differences block: defaults and shared types
package rgd_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef struct packed {
      logic busy;
      logic done;
   } gcd_status_type;

endpackage

[rtl/core/rgd_gcd_unit.sv]
// iterative binary gcd unit: one compare, subtract or shift step per cycle
module rgd_gcd_unit #(
   parameter int DATA_WIDTH = rgd_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [DATA_WIDTH-1:0]  op_a,
   input  logic [DATA_WIDTH-1:0]  op_b,
   output rgd_pkg::gcd_status_type status,
   output logic [DATA_WIDTH-1:0]  result
);

   localparam int KW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

   logic                  busy_ff, busy_in;
   logic [DATA_WIDTH-1:0] a_ff, a_in;
   logic [DATA_WIDTH-1:0] b_ff, b_in;
   logic [KW-1:0]         k_ff, k_in;
   logic                  finish;
   logic                  a_ge_b;
   logic [DATA_WIDTH-1:0] a_minus_b;
   logic [DATA_WIDTH-1:0] b_minus_a;

   assign finish    = busy_ff && ((a_ff == '0) || (b_ff == '0));
   assign a_ge_b    = (a_ff >= b_ff);
   assign a_minus_b = a_ff - b_ff;
   assign b_minus_a = b_ff - a_ff;

   always_comb begin
      busy_in = busy_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      if (start) begin
         busy_in = 1'b1;
         a_in    = op_a;
         b_in    = op_b;
         k_in    = '0;
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + KW'(1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ge_b) begin
            a_in = a_minus_b >> 1;
         end else begin
            b_in = b_minus_a >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      k_ff <= k_in;
   end

   assign status.busy = busy_ff;
   assign status.done = finish;
   assign result      = (a_ff | b_ff) << k_ff;

endmodule

[rtl/core/running_gcd_of_differences_top.sv]
// top level of the running gcd of differences block
//
// req channel: one signed sample per beat, req_last marks the final beat of a set.
// rsp channel: one beat per set, sent after the beat with req_last; rsp_gcd_value
// holds the gcd of the absolute differences of every sample from the first one,
// rsp_all_equal is set (and rsp_gcd_value is zero) when all samples matched.
// Only one sample is in work at a time; req_stall is high while it is.
// The first sample of a set is stored as the reference. A later sample loads its
// difference into the binary gcd unit, which then works through its compare,
// subtract and shift steps; the control sees the unit finish and stores the
// result as the new running gcd.
// The result sits in an output register; a stalled rsp beat holds and the
// next samples are still taken, until another set end has to wait for it.
// Reset (synchronous, active high) drops any set in progress and any
// pending rsp beat.
module running_gcd_of_differences_top #(
   parameter int DATA_WIDTH = rgd_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DATA_WIDTH-1:0] req_sample,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_WIDTH-1:0] rsp_gcd_value,
   output logic                  rsp_all_equal
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [DATA_WIDTH-1:0] reference_ff, reference_in;
   logic [DATA_WIDTH-1:0] running_ff, running_in;
   logic                  have_ref_ff, have_ref_in;
   logic                  last_ff, last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_gcd_ff, rsp_gcd_in;
   logic                  rsp_eq_ff, rsp_eq_in;

   logic                  req_take;
   logic                  out_free;
   logic                  out_load;
   logic                  gcd_start;
   logic [DATA_WIDTH:0]   diff;
   logic [DATA_WIDTH:0]   diff_abs;
   logic [DATA_WIDTH-1:0] gcd_result;
   rgd_pkg::gcd_status_type gcd_status;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = (state_ff == ST_DONE) && last_ff && out_free;
   assign gcd_start = req_take && have_ref_ff;

   // sign-extended difference, then its magnitude
   assign diff     = {req_sample[DATA_WIDTH-1], req_sample}
                   - {reference_ff[DATA_WIDTH-1], reference_ff};
   assign diff_abs = diff[DATA_WIDTH] ? (~diff + (DATA_WIDTH+1)'(1)) : diff;

   rgd_gcd_unit #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (gcd_start),
      .op_a   (running_ff),
      .op_b   (diff_abs[DATA_WIDTH-1:0]),
      .status (gcd_status),
      .result (gcd_result)
   );

   always_comb begin
      state_in     = state_ff;
      reference_in = reference_ff;
      running_in   = running_ff;
      have_ref_in  = have_ref_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_gcd_in   = rsp_gcd_ff;
      rsp_eq_in    = rsp_eq_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               last_in = req_last;
               if (!have_ref_ff) begin
                  reference_in = req_sample;
                  have_ref_in  = 1'b1;
                  state_in     = ST_DONE;
               end else begin
                  state_in = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            if (gcd_status.done) begin
               running_in = gcd_result;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_gcd_in   = running_ff;
               rsp_eq_in    = (running_ff == '0);
               reference_in = '0;
               running_in   = '0;
               have_ref_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         reference_ff <= '0;
         running_ff   <= '0;
         have_ref_ff  <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reference_ff <= reference_in;
         running_ff   <= running_in;
         have_ref_ff  <= have_ref_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_gcd_ff <= rsp_gcd_in;
      rsp_eq_ff  <= rsp_eq_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_gcd_value = rsp_gcd_ff;
   assign rsp_all_equal = rsp_eq_ff;

   // gcd unit only restarted when idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      gcd_start |-> !gcd_status.busy)
      else $error("gcd unit started while busy");

   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      gcd_status.done |-> (state_ff == ST_CALC))
      else $error("gcd result outside calc state");

   a_equal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_eq_ff) |-> (rsp_gcd_ff == '0))
      else $error("all_equal with nonzero gcd");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (!have_ref_ff && (running_ff == '0) && rsp_valid_ff))
      else $error("set state not cleared after result");

endmodule

[tb/running_gcd_of_differences_top_tb.sv]
// self-checking testbench for the running gcd of differences block
module running_gcd_of_differences_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = rgd_pkg::DATA_WIDTH_DEFAULT;
   localparam int ITEM_TARGET = 2000;
   localparam int DRAIN_CYCLES = 2 * DW + 16;
   localparam logic [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};

   typedef struct packed {
      logic [DW-1:0] gcd_value;
      logic          all_equal;
   } gcd_result_type;

   class set_gcd_tracker;
      logic [DW-1:0]  reference;
      logic [DW-1:0]  running_gcd;
      bit             have_reference;
      gcd_result_type owed_gcds[$];
      int             errors;

      function automatic logic [DW-1:0] abs_distance(logic [DW-1:0] a,
                                                     logic [DW-1:0] b);
         logic signed [DW:0] d;
         d = $signed({a[DW-1], a}) - $signed({b[DW-1], b});
         if (d < 0) begin
            d = -d;
         end
         return d[DW-1:0];
      endfunction

      function automatic logic [DW-1:0] euclid(logic [DW-1:0] a, logic [DW-1:0] b);
         logic [DW-1:0] t;
         while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
         end
         return a;
      endfunction

      function void take_sample(logic [DW-1:0] s, logic is_last);
         gcd_result_type r;
         if (!have_reference) begin
            reference = s;
            have_reference = 1;
         end else begin
            running_gcd = euclid(running_gcd, abs_distance(s, reference));
         end
         if (is_last) begin
            r.gcd_value = running_gcd;
            r.all_equal = (running_gcd == 0);
            owed_gcds.push_back(r);
            reference = 0;
            running_gcd = 0;
            have_reference = 0;
         end
      endfunction

      function void check_result(logic [DW-1:0] gcd_value, logic all_equal);
         gcd_result_type want;
         if (owed_gcds.size() == 0) begin
            errors++;
            if (errors <= 10) begin
               $display("unexpected rsp beat: gcd_value=%h all_equal=%b",
                        gcd_value, all_equal);
            end
            return;
         end
         want = owed_gcds.pop_front();
         if (gcd_value !== want.gcd_value || all_equal !== want.all_equal) begin
            errors++;
            if (errors <= 10) begin
               $display({"rsp mismatch: expected gcd_value=%h all_equal=%b,",
                         " got gcd_value=%h all_equal=%b"},
                        want.gcd_value, want.all_equal, gcd_value, all_equal);
            end
         end
      endfunction

      function int outstanding();
         return owed_gcds.size();
      endfunction
   endclass

   logic          clock = 0;
   logic          reset = 1;
   logic          req_valid = 0;
   logic          req_stall;
   logic [DW-1:0] req_sample = '0;
   logic          req_last = 0;
   logic          rsp_valid;
   logic          rsp_stall = 0;
   logic [DW-1:0] rsp_gcd_value;
   logic          rsp_all_equal;

   set_gcd_tracker sb;
   logic [DW-1:0]  set_vals[$];
   int             items_sent = 0;
   int             stall_left = 0;
   bit             quiet = 0;

   running_gcd_of_differences_top #(.DATA_WIDTH(DW)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_gcd_value(rsp_gcd_value),
      .rsp_all_equal(rsp_all_equal)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int pick_gap(int short_max, int long_lo, int long_hi);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, short_max);
      end
      return $urandom_range(long_lo, long_hi);
   endfunction

   // result side: check accepted beats, random stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_gcd_value, rsp_all_equal);
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else begin
         stall_left <= pick_gap(4, 15, 150);
         rsp_stall <= 0;
      end
   end

   task automatic send_beat(logic [DW-1:0] s, logic is_last);
      int gap;
      gap = pick_gap(3, 10, 120);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_sample <= s;
      req_last <= is_last;
      do @(posedge clock); while (req_stall);
      sb.take_sample(s, is_last);
      items_sent++;
   endtask

   task automatic send_set();
      for (int i = 0; i < set_vals.size(); i++) begin
         send_beat(set_vals[i], i == set_vals.size() - 1);
      end
      set_vals.delete();
   endtask

   task automatic random_set();
      int            len;
      int            mode;
      logic [DW-1:0] base;
      logic [DW-1:0] step;
      logic [DW-1:0] v;
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      mode = $urandom_range(0, 9);
      quiet = ($urandom_range(0, 4) == 0);
      base = $urandom();
      step = (DW'(1) << $urandom_range(0, 20)) * $urandom_range(1, 15);
      if (mode == 8) begin
         base = $urandom_range(0, 1) ? S_MIN : S_MAX;
         step = $urandom() >> $urandom_range(1, 8);
      end
      for (int i = 0; i < len; i++) begin
         case (mode)
            0, 1, 2, 3, 8: v = base + step * $urandom_range(0, 40) - step * 20;
            4: v = base;
            5: v = $urandom();
            6: begin
               case ($urandom_range(0, 4))
                  0: v = S_MIN;
                  1: v = S_MAX;
                  2: v = '0;
                  3: v = '1;
                  default: v = 1;
               endcase
            end
            default: v = DW'($urandom_range(0, 100)) - DW'(50);
         endcase
         set_vals.push_back(v);
      end
      send_set();
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 0;

      // single-value sets: the extremes, zero and all ones
      set_vals = '{S_MIN};               send_set();
      set_vals = '{S_MAX};               send_set();
      set_vals = '{DW'(0)};              send_set();
      set_vals = '{'1};                  send_set();
      // largest possible difference, both orders
      set_vals = '{S_MIN, S_MAX};        send_set();
      set_vals = '{S_MAX, S_MIN};        send_set();
      // all equal, then sets with differing values
      set_vals = '{DW'(7), DW'(7), DW'(7)};           send_set();
      set_vals = '{DW'(0), DW'(6), DW'(10)};          send_set();
      set_vals = '{DW'(5), -DW'(7), DW'(5)};          send_set();
      set_vals = '{'1, DW'(0)};                       send_set();
      set_vals = '{DW'(100), DW'(100), DW'(130)};     send_set();
      set_vals = '{S_MIN, S_MIN + DW'(1024), S_MIN + DW'(4096)}; send_set();

      while (items_sent < ITEM_TARGET) begin
         random_set();
      end
      req_valid <= 0;
      quiet = 0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/rgd_pkg.sv
rtl/core/rgd_gcd_unit.sv
rtl/core/running_gcd_of_differences_top.sv
tb/running_gcd_of_differences_top_tb.sv
